/* rtl/sqroi_pkg.sv */
// shared types, codes and helpers of the square roi area sorted table
// no dependencies
package sqroi_pkg;

   localparam int COORD_W = 12;
   localparam int SIDE_W  = 13;
   localparam int AREA_W  = 25;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_SMALL    = 3'd1;
   localparam logic [2:0] ST_HELD     = 3'd2;
   localparam logic [2:0] ST_DROPPED  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MIN_SIDE     = 2'd2;
   localparam logic [1:0] REG_GROW_PAD     = 2'd3;

   localparam logic [12:0] DIM_MAX = 13'd4096;

   typedef struct packed {
      logic [SIDE_W-1:0]  h;
      logic [SIDE_W-1:0]  w;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } box_type;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      box_type           box;
   } entry_type;

   function automatic logic [SIDE_W-1:0] clamp_dim(input logic [SIDE_W-1:0] d);
      logic [SIDE_W-1:0] r;
      r = d;
      if (d == '0) r = 13'd1;
      else if (d > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

endpackage

/* rtl/sqroi_hold.sv */
// containment compare: outer box holds inner box
// depends on sqroi_pkg
module sqroi_hold import sqroi_pkg::*; (
   input  box_type outer,
   input  box_type inner,
   output logic    holds
);
   logic [SIDE_W:0] outer_r, outer_b, inner_r, inner_b;

   always_comb begin
      outer_r = {2'b0, outer.x} + {1'b0, outer.w};
      outer_b = {2'b0, outer.y} + {1'b0, outer.h};
      inner_r = {2'b0, inner.x} + {1'b0, inner.w};
      inner_b = {2'b0, inner.y} + {1'b0, inner.h};
      holds = (outer.x <= inner.x) && (outer.y <= inner.y) &&
              (outer_r >= inner_r) && (outer_b >= inner_b);
   end
endmodule

/* rtl/square_roi_area_sorted_table.sv */
// Square roi table sorted by descending area. An offer item (tuser 0) is
// grown as it is taken; its width is then cut to the smaller side, and it is
// clipped and measured (states ADJ1, ADJ2 and AREA). It is then scanned
// against the table entry by entry, through one registered read port of the
// entry memory and one shared containment compare. Insertion walks the rest of
// the table and compacts contained entries in place. A dump (tuser 1) gives the
// entries in table order and clears the table. The block takes no item while
// one is in work. There is no clearing pass after reset.
// depends on sqroi_pkg and sqroi_hold
module square_roi_area_sorted_table import sqroi_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // box_x, box_y, box_w, box_h
   input  logic                  req_tuser,  // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status, rect_x, rect_y, rect_w, rect_h
   output logic [1:0]            rsp_tuser,  // kind
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [12:0]           csr_wdata
);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADJ1 = 4'd1;
   localparam logic [3:0] S_ADJ2 = 4'd2;
   localparam logic [3:0] S_AREA = 4'd3;
   localparam logic [3:0] S_SCRD = 4'd4;
   localparam logic [3:0] S_SCEV = 4'd5;
   localparam logic [3:0] S_INS  = 4'd6;
   localparam logic [3:0] S_INRD = 4'd7;
   localparam logic [3:0] S_INEV = 4'd8;
   localparam logic [3:0] S_EMIT = 4'd9;
   localparam logic [3:0] S_DMRD = 4'd10;
   localparam logic [3:0] S_DMEV = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [12:0]        iw_cfg_ff, iw_cfg_in, ih_cfg_ff, ih_cfg_in, min_ff, min_in;
   logic [7:0]         pad_ff, pad_in;
   logic [1:0]         kind_ff, kind_in;
   logic [2:0]         stat_ff, stat_in;
   logic [12:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic [11:0]        x_ff, x_in, y_ff, y_in;
   logic [12:0]        w_ff, w_in, h_ff, h_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   logic [CW-1:0]      idx_ff, idx_in, wp_ff, wp_in, count_ff, count_in;
   entry_type          pend_ff, pend_in, rd_ff;
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   entry_type          mem_ff [MAX_ENTRIES];
   logic               mem_we;
   logic [AW-1:0]      mem_wa;

   logic [12:0]        iw, ih, bw, bh, w2, hw, hh, x0, y0;
   logic [11:0]        bx, by;
   logic [13:0]        gw, gh, sx, sy;
   logic [25:0]        prod;
   logic               out_free, holds;
   box_type            new_box, hold_outer, hold_inner;

   assign iw = clamp_dim(iw_cfg_ff);
   assign ih = clamp_dim(ih_cfg_ff);
   assign bx = req_tdata[11:0];
   assign by = req_tdata[23:12];
   assign bw = req_tdata[36:24];
   assign bh = req_tdata[49:37];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign new_box = '{h: h_ff, w: w_ff, y: y_ff, x: x_ff};

   assign hold_outer = (state_ff == S_INEV) ? new_box : rd_ff.box;
   assign hold_inner = (state_ff == S_INEV) ? rd_ff.box : new_box;

   sqroi_hold u_hold (
      .outer (hold_outer),
      .inner (hold_inner),
      .holds (holds)
   );

   always_comb begin
      iw_cfg_in = iw_cfg_ff;
      ih_cfg_in = ih_cfg_ff;
      min_in    = min_ff;
      pad_in    = pad_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_IMAGE_WIDTH:  iw_cfg_in = csr_wdata;
            REG_IMAGE_HEIGHT: ih_cfg_in = csr_wdata;
            REG_MIN_SIDE:     min_in    = csr_wdata;
            REG_GROW_PAD:     pad_in    = csr_wdata[7:0];
            default:          pad_in    = pad_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      stat_in  = stat_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      area_in  = area_ff;
      idx_in   = idx_ff;
      wp_in    = wp_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      mem_we   = 1'b0;
      mem_wa   = wp_ff[AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      gw   = {1'b0, bw} + {6'b0, pad_ff};
      gh   = {1'b0, bh} + {6'b0, pad_ff};
      w2   = (w_ff > h_ff) ? h_ff : w_ff;
      hw   = w2 >> 1;
      hh   = h_ff >> 1;
      x0   = (cx_ff > hw) ? cx_ff - hw : 13'd0;
      y0   = (cy_ff > hh) ? cy_ff - hh : 13'd0;
      sx   = {2'b0, x_ff} + {1'b0, w_ff};
      sy   = {2'b0, y_ff} + {1'b0, h_ff};
      prod = w_ff * h_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = KIND_STATUS;
               stat_in = ST_INSERTED;
               idx_in  = '0;
               if (req_tuser) begin
                  if (count_ff == '0) begin
                     kind_in  = KIND_EMPTY;
                     {x_in, y_in, w_in, h_in} = '0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_DMRD;
                  end
               end else if (bh < min_ff || bw < min_ff) begin
                  stat_in  = ST_SMALL;
                  {x_in, y_in, w_in, h_in} = '0;
                  state_in = S_EMIT;
               end else begin
                  cx_in = {1'b0, bx} + {1'b0, bw[12:1]};
                  cy_in = {1'b0, by} + {1'b0, bh[12:1]};
                  w_in  = (gw > {1'b0, iw}) ? iw : gw[12:0];
                  h_in  = (gh > {1'b0, ih}) ? ih : gh[12:0];
                  state_in = S_ADJ1;
               end
            end
         end
         S_ADJ1: begin
            w_in = w2;
            x_in = (x0 >= iw) ? 12'(iw - 13'd1) : x0[11:0];
            y_in = (y0 >= ih) ? 12'(ih - 13'd1) : y0[11:0];
            state_in = S_ADJ2;
         end
         S_ADJ2: begin
            if (sx > {1'b0, iw}) w_in = iw - {1'b0, x_ff};
            if (sy > {1'b0, ih}) h_in = ih - {1'b0, y_ff};
            state_in = S_AREA;
         end
         S_AREA: begin
            area_in  = prod[AREA_W-1:0];
            state_in = S_SCRD;
         end
         S_SCRD: begin
            state_in = (idx_ff == count_ff) ? S_INS : S_SCEV;
         end
         S_SCEV: begin
            if (area_ff < rd_ff.area) begin
               if (holds) begin
                  stat_in  = ST_HELD;
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_SCRD;
               end
            end else begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (idx_ff >= CW'(MAX_ENTRIES)) begin
               stat_in  = ST_FULL;
               state_in = S_EMIT;
            end else begin
               wp_in    = idx_ff;
               pend_in  = '{area: area_ff, box: new_box};
               state_in = S_INRD;
            end
         end
         S_INRD: begin
            if (idx_ff == count_ff) begin
               if (wp_ff < CW'(MAX_ENTRIES)) begin
                  mem_we   = 1'b1;
                  count_in = wp_ff + CW'(1);
               end else begin
                  count_in = CW'(MAX_ENTRIES);
                  stat_in  = ST_DROPPED;
               end
               state_in = S_EMIT;
            end else begin
               state_in = S_INEV;
            end
         end
         S_INEV: begin
            if (!holds) begin
               mem_we  = 1'b1;
               wp_in   = wp_ff + CW'(1);
               pend_in = rd_ff;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_INRD;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {3'b0, h_ff, w_ff, y_ff, x_ff, stat_ff};
               state_in     = S_IDLE;
            end
         end
         S_DMRD: begin
            state_in = S_DMEV;
         end
         S_DMEV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ENTRY;
               rsp_last_in  = (idx_ff + CW'(1) == count_ff);
               rsp_data_in  = {3'b0, rd_ff.box, ST_INSERTED};
               idx_in       = idx_ff + CW'(1);
               if (idx_ff + CW'(1) == count_ff) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DMRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_wa] <= pend_ff;
      rd_ff <= mem_ff[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         iw_cfg_ff    <= 13'd640;
         ih_cfg_ff    <= 13'd480;
         min_ff       <= 13'd30;
         pad_ff       <= 8'd20;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         iw_cfg_ff    <= iw_cfg_in;
         ih_cfg_ff    <= ih_cfg_in;
         min_ff       <= min_in;
         pad_ff       <= pad_in;
      end
      kind_ff     <= kind_in;
      stat_ff     <= stat_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      area_ff     <= area_in;
      idx_ff      <= idx_in;
      wp_ff       <= wp_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

/* rtl/sqroi_chk.sv */
// port-level checks for square_roi_area_sorted_table, bound to the top level
// depends on sqroi_pkg
module sqroi_chk import sqroi_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_STATUS || rsp_tuser == KIND_EMPTY) |-> rsp_tlast)
      else $error("offer status or empty marker without tlast");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tdata[2:0] <= ST_FULL)
      else $error("undefined offer status");
endmodule

bind square_roi_area_sorted_table sqroi_chk u_sqroi_chk (.*);
